// ===== sv/rpta_pkg.sv =====
package rpta_pkg;

  // Tile and field geometry.
  localparam int TILE_PIXELS = 65536;
  localparam int SLOT_W      = $clog2(TILE_PIXELS);
  localparam int PIX_W       = 16;
  localparam int RAS_W       = 12;
  localparam int SMP_W       = 16;
  localparam int AGG_W       = 32;

  // Mean datapath: old * raster + sample, then a divide by raster + 1.
  localparam int PROD_W     = AGG_W + RAS_W + 1;
  localparam int MAG_W      = PROD_W - 1;
  localparam int DVSR_W     = RAS_W + 1;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = AGG_W / DIV_BITS;

  typedef enum logic [1:0] {
    MODE_MEAN = 2'd0,
    MODE_MIN  = 2'd1,
    MODE_MAX  = 2'd2,
    MODE_SUM  = 2'd3
  } agg_mode_t;

  typedef enum logic {
    REG_AGG_MODE = 1'b0,
    REG_NODATA   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0]        pixel_index;
    logic [RAS_W-1:0]        raster_index;
    logic signed [SMP_W-1:0] sample;
  } px_item_t;

  typedef struct packed {
    logic [PIX_W-1:0]        out_pixel_index;
    logic signed [AGG_W-1:0] aggregate_value;
  } agg_item_t;

endpackage

// ===== sv/raster_pixel_temporal_aggregator_core.sv =====
// Items pass stages A, B, C, the divider and the output register. Throughput: one item
// per cycle unless the output stalls. An item with a non-zero raster index waits while an
// earlier item for the same pixel is still in the 12 stages ahead of the store write-back.
// The mean divide is an 8-stage pipelined divider retiring 4 quotient bits per stage.
// Reset clears the pipeline and sets both registers to 0; the aggregate store is not
// cleared, so each pixel must first be written by an item with raster index 0.
module raster_pixel_temporal_aggregator_core
  import rpta_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            px_valid,
  output logic            px_ready,
  input  px_item_t        px_data,
  output logic            agg_valid,
  input  logic            agg_ready,
  output agg_item_t       agg_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  cfg_reg_t        cfg_index,
  input  logic [SMP_W-1:0] cfg_data
);

  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] pix;
    logic             use_div;
    logic [AGG_W-1:0] res;
  } ctl_t;

  function automatic logic [DVSR_W+AGG_W-1:0] div_step(input logic [DVSR_W-1:0] rem,
                                                       input logic [AGG_W-1:0]  quo,
                                                       input logic [DVSR_W-1:0] dvsr);
    logic [DVSR_W-1:0] r;
    logic [DVSR_W-1:0] t;
    logic [AGG_W-1:0]  q;
    r = rem;
    q = quo;
    for (int k = 0; k < DIV_BITS; k++) begin
      t = {r[DVSR_W-2:0], q[AGG_W-1]};
      q = {q[AGG_W-2:0], 1'b0};
      if (t >= dvsr) begin
        t    = t - dvsr;
        q[0] = 1'b1;
      end
      r = t;
    end
    return {r, q};
  endfunction

  // Configuration.
  agg_mode_t               agg_mode;
  logic signed [SMP_W-1:0] nodata;

  // Store and its registered read port.
  logic [AGG_W-1:0] store [TILE_PIXELS];
  logic [AGG_W-1:0] rd_q;

  // Stage A: item accepted, store read in flight.
  logic     a_valid;
  px_item_t a_item;

  // Stage B: old value resolved, product formed.
  ctl_t                     b_ctl;
  ctl_t                     b_ctl_next;
  logic signed [PROD_W-1:0] b_prod;
  logic signed [SMP_W-1:0]  b_s;
  logic [DVSR_W-1:0]        b_dvsr;

  // Stage C: dividend formed.
  ctl_t                     c_ctl;
  logic signed [PROD_W-1:0] c_num;
  logic [DVSR_W-1:0]        c_dvsr;

  // Divider stages: index 0 holds the initial remainder, the last holds the quotient.
  ctl_t              dv_ctl  [DIV_STAGES+1];
  logic              dv_neg  [DIV_STAGES+1];
  logic [DVSR_W-1:0] dv_dvsr [DIV_STAGES+1];
  logic [DVSR_W-1:0] dv_rem  [DIV_STAGES+1];
  logic [AGG_W-1:0]  dv_quo  [DIV_STAGES+1];

  logic                     advance;
  logic                     hazard;
  logic                     accept;
  logic [SLOT_W-1:0]        in_slot;
  logic signed [AGG_W-1:0]  old;
  logic signed [AGG_W-1:0]  nd32;
  logic signed [AGG_W-1:0]  s32;
  logic [PROD_W-1:0]        c_abs;
  logic [AGG_W-1:0]         quo_fin;
  logic [AGG_W-1:0]         final_res;
  logic                     wr_en;
  logic [SLOT_W-1:0]        wr_slot;

  assign cfg_ready = 1'b1;
  assign advance   = !agg_valid || agg_ready;
  assign in_slot   = px_data.pixel_index[SLOT_W-1:0];
  assign accept    = px_valid && px_ready;

  // An item that reads the store must not overtake a pending write to its pixel.
  always_comb begin
    hazard = 1'b0;
    if (a_valid && a_item.pixel_index[SLOT_W-1:0] == in_slot) hazard = 1'b1;
    if (b_ctl.valid && b_ctl.pix[SLOT_W-1:0] == in_slot) hazard = 1'b1;
    if (c_ctl.valid && c_ctl.pix[SLOT_W-1:0] == in_slot) hazard = 1'b1;
    for (int k = 0; k <= DIV_STAGES; k++) begin
      if (dv_ctl[k].valid && dv_ctl[k].pix[SLOT_W-1:0] == in_slot) hazard = 1'b1;
    end
    if (px_data.raster_index == '0) hazard = 1'b0;
  end

  assign px_ready = advance && !hazard;

  // Stage B logic.
  always_comb begin
    nd32 = {{(AGG_W-SMP_W){nodata[SMP_W-1]}}, nodata};
    s32  = {{(AGG_W-SMP_W){a_item.sample[SMP_W-1]}}, a_item.sample};
    if (a_item.raster_index == '0) begin
      old = (agg_mode == MODE_MIN) ? nd32 : '0;
    end else begin
      old = rd_q;
    end
    b_ctl_next.valid   = a_valid;
    b_ctl_next.pix     = a_item.pixel_index;
    b_ctl_next.use_div = 1'b0;
    b_ctl_next.res     = old;
    case (agg_mode)
      MODE_MEAN: begin
        if (a_item.sample == nodata) begin
          b_ctl_next.res = nd32;
        end else begin
          b_ctl_next.use_div = 1'b1;
        end
      end
      MODE_MIN: begin
        if (old == nd32 || old > s32) b_ctl_next.res = s32;
      end
      MODE_MAX: begin
        if (old == nd32 || old < s32) b_ctl_next.res = s32;
      end
      MODE_SUM: begin
        if (a_item.sample != nodata) b_ctl_next.res = old + s32;
      end
      default: b_ctl_next.res = old;
    endcase
  end

  assign c_abs     = c_num[PROD_W-1] ? PROD_W'(-c_num) : c_num;
  assign quo_fin   = dv_quo[DIV_STAGES];
  assign final_res = !dv_ctl[DIV_STAGES].use_div ? dv_ctl[DIV_STAGES].res
                   : dv_neg[DIV_STAGES] ? AGG_W'(-quo_fin) : quo_fin;
  assign wr_en     = advance && dv_ctl[DIV_STAGES].valid;
  assign wr_slot   = dv_ctl[DIV_STAGES].pix[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_q <= store[in_slot];
    end
    if (wr_en) begin
      store[wr_slot] <= final_res;
    end
  end

  // Pipeline: valid bits, configuration and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      agg_mode    <= MODE_MEAN;
      nodata      <= '0;
      a_valid     <= 1'b0;
      b_ctl.valid <= 1'b0;
      c_ctl.valid <= 1'b0;
      for (int k = 0; k <= DIV_STAGES; k++) dv_ctl[k].valid <= 1'b0;
      agg_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_AGG_MODE: agg_mode <= agg_mode_t'(cfg_data[1:0]);
          REG_NODATA:   nodata   <= cfg_data;
          default:      ;
        endcase
      end
      if (advance) begin
        a_valid          <= accept;
        b_ctl.valid      <= b_ctl_next.valid;
        c_ctl.valid      <= b_ctl.valid;
        dv_ctl[0].valid  <= c_ctl.valid;
        for (int k = 1; k <= DIV_STAGES; k++) dv_ctl[k].valid <= dv_ctl[k-1].valid;
        agg_valid        <= dv_ctl[DIV_STAGES].valid;

        a_item <= px_data;

        b_ctl.pix     <= b_ctl_next.pix;
        b_ctl.use_div <= b_ctl_next.use_div;
        b_ctl.res     <= b_ctl_next.res;
        b_prod        <= old * $signed({1'b0, a_item.raster_index});
        b_s           <= a_item.sample;
        b_dvsr        <= DVSR_W'(a_item.raster_index) + 1'b1;

        c_ctl.pix     <= b_ctl.pix;
        c_ctl.use_div <= b_ctl.use_div;
        c_ctl.res     <= b_ctl.res;
        c_num         <= b_prod + {{(PROD_W-SMP_W){b_s[SMP_W-1]}}, b_s};
        c_dvsr        <= b_dvsr;

        // The quotient magnitude is below 2^32, so the top bits start as the remainder.
        dv_ctl[0].pix     <= c_ctl.pix;
        dv_ctl[0].use_div <= c_ctl.use_div;
        dv_ctl[0].res     <= c_ctl.res;
        dv_neg[0]         <= c_num[PROD_W-1];
        dv_dvsr[0]        <= c_dvsr;
        dv_rem[0]         <= {1'b0, c_abs[MAG_W-1:AGG_W]};
        dv_quo[0]         <= c_abs[AGG_W-1:0];

        for (int k = 1; k <= DIV_STAGES; k++) begin
          dv_ctl[k].pix            <= dv_ctl[k-1].pix;
          dv_ctl[k].use_div        <= dv_ctl[k-1].use_div;
          dv_ctl[k].res            <= dv_ctl[k-1].res;
          dv_neg[k]                <= dv_neg[k-1];
          dv_dvsr[k]               <= dv_dvsr[k-1];
          {dv_rem[k], dv_quo[k]}   <= div_step(dv_rem[k-1], dv_quo[k-1], dv_dvsr[k-1]);
        end

        agg_data.out_pixel_index <= dv_ctl[DIV_STAGES].pix;
        agg_data.aggregate_value <= final_res;
      end
    end
  end

  // The dividend must never give a quotient too wide for the divider.
  a_div_init_fits: assert property (@(posedge clk) disable iff (rst)
    dv_ctl[0].valid && dv_ctl[0].use_div |-> dv_rem[0] < dv_dvsr[0])
    else $error("divider initial remainder not below divisor");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (rst)
    dv_ctl[DIV_STAGES].valid && dv_ctl[DIV_STAGES].use_div
      |-> dv_rem[DIV_STAGES] < dv_dvsr[DIV_STAGES])
    else $error("divider final remainder not below divisor");

  a_no_stale_read: assert property (@(posedge clk) disable iff (rst)
    wr_en && accept && px_data.raster_index != '0 |-> wr_slot != in_slot)
    else $error("store read overtook a pending write to the same pixel");

endmodule

// ===== verif/tb_raster_pixel_temporal_aggregator_core.sv =====
module tb_raster_pixel_temporal_aggregator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import rpta_pkg::*;

  localparam int DRAIN_CYCLES = 24;

  logic            clk;
  logic            rst;
  logic            px_valid;
  logic            px_ready;
  px_item_t        px_data;
  logic            agg_valid;
  logic            agg_ready = 1'b0;
  agg_item_t       agg_data;
  logic            cfg_valid;
  logic            cfg_ready;
  cfg_reg_t        cfg_index;
  logic [SMP_W-1:0] cfg_data;

  // Copy of the block's registers and of its per-pixel aggregate store.
  agg_mode_t               cur_mode;
  logic signed [SMP_W-1:0] cur_nodata;
  logic signed [AGG_W-1:0] pixel_agg [TILE_PIXELS];
  bit                      pixel_seen [TILE_PIXELS];
  logic [PIX_W-1:0]        seen_pixels [$];
  agg_item_t               pending_aggs [$];

  int   mismatch_count = 0;
  bit   tx_gaps = 1'b0;
  int   tx_burst_left = 0;
  bit   rx_random = 1'b0;
  bit   rx_stalling = 1'b0;
  int   rx_run_left = 0;
  logic hold_active = 1'b0;
  int   hold_off_len = 0;
  event hold_off_ev;

  raster_pixel_temporal_aggregator_core DUT (
    .clk       (clk),
    .rst       (rst),
    .px_valid  (px_valid),
    .px_ready  (px_ready),
    .px_data   (px_data),
    .agg_valid (agg_valid),
    .agg_ready (agg_ready),
    .agg_data  (agg_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Folds one item into the aggregate store and returns the result it should produce.
  function automatic agg_item_t fold_pixel(input px_item_t item);
    longint    nodata;
    longint    smp;
    longint    ras;
    longint    prev;
    longint    next_val;
    int        slot;
    agg_item_t res;
    nodata = longint'(cur_nodata);
    smp    = longint'(item.sample);
    ras    = longint'(item.raster_index);
    slot   = item.pixel_index % TILE_PIXELS;
    if (ras == 0) begin
      prev = (cur_mode == MODE_MIN) ? nodata : 0;
    end else begin
      prev = longint'(pixel_agg[slot]);
    end
    case (cur_mode)
      MODE_MEAN: next_val = (smp == nodata) ? nodata : (prev * ras + smp) / (ras + 1);
      MODE_MIN:  next_val = (prev == nodata || prev > smp) ? smp : prev;
      MODE_MAX:  next_val = (prev == nodata || prev < smp) ? smp : prev;
      default:   next_val = (smp == nodata) ? prev : prev + smp;
    endcase
    pixel_agg[slot] = next_val[AGG_W-1:0];
    if (!pixel_seen[slot]) begin
      pixel_seen[slot] = 1'b1;
      seen_pixels = {seen_pixels, item.pixel_index};
    end
    res.out_pixel_index = item.pixel_index;
    res.aggregate_value = pixel_agg[slot];
    return res;
  endfunction

  function automatic bit count_mismatch();
    mismatch_count++;
    return mismatch_count <= 10;
  endfunction

  function automatic logic signed [SMP_W-1:0] pick_sample();
    int roll;
    int near_zero;
    roll = $urandom_range(0, 99);
    near_zero = $urandom_range(0, 6);
    if (roll < 18) return cur_nodata;
    if (roll < 26) return 16'sh7FFF;
    if (roll < 34) return 16'sh8000;
    if (roll < 50) return SMP_W'(near_zero - 3);
    return SMP_W'($urandom_range(0, 65535));
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic [RAS_W-1:0] ras,
                            input logic signed [SMP_W-1:0] smp);
    px_item_t  item;
    agg_item_t want_item;
    item.pixel_index  = pix;
    item.raster_index = ras;
    item.sample       = smp;
    if (tx_gaps && tx_burst_left == 0) begin
      tx_burst_left = $urandom_range(1, 24);
      px_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    if (tx_burst_left > 0) tx_burst_left--;
    px_valid <= 1'b1;
    px_data  <= item;
    do @(posedge clk); while (!px_ready);
    want_item    = fold_pixel(item);
    pending_aggs = {pending_aggs, want_item};
  endtask

  task automatic wait_results_drained();
    px_valid <= 1'b0;
    while (pending_aggs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Both registers are written back to back, so cfg_valid stays high between them.
  task automatic reconfigure(input agg_mode_t mode, input logic signed [SMP_W-1:0] nodata);
    wait_results_drained();
    cfg_valid <= 1'b1;
    cfg_index <= REG_AGG_MODE;
    cfg_data  <= {{(SMP_W-2){1'b0}}, mode};
    do @(posedge clk); while (!cfg_ready);
    cur_mode = mode;
    cfg_index <= REG_NODATA;
    cfg_data  <= nodata;
    do @(posedge clk); while (!cfg_ready);
    cur_nodata = nodata;
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed stacks on a handful of pixels, with raster jumps and stray pixels.
  task automatic random_stacks(input int n_items);
    logic [PIX_W-1:0] stack_pix [24];
    int               stack_next [24];
    int               n_stacks;
    int               k;
    int               roll;
    int               sent;
    n_stacks = $urandom_range(1, 24);
    for (k = 0; k < n_stacks; k++) begin
      stack_pix[k]  = PIX_W'($urandom_range(0, 65535));
      stack_next[k] = 0;
    end
    for (sent = 0; sent < n_items; sent++) begin
      roll = $urandom_range(0, 99);
      k    = $urandom_range(0, n_stacks - 1);
      if (roll < 75) begin
        if (stack_next[k] > 4095) stack_next[k] = 0;
        send_pixel(stack_pix[k], RAS_W'(stack_next[k]), pick_sample());
        stack_next[k]++;
      end else if (roll < 85 && stack_next[k] > 0) begin
        send_pixel(stack_pix[k], RAS_W'($urandom_range(1, 4095)), pick_sample());
      end else if (roll < 93 || seen_pixels.size() == 0) begin
        send_pixel(PIX_W'($urandom_range(0, 65535)), '0, pick_sample());
      end else begin
        send_pixel(seen_pixels[$urandom_range(0, seen_pixels.size() - 1)],
                   RAS_W'($urandom_range(0, 4095)), pick_sample());
      end
    end
  endtask

  // Registers are left at their reset values: mean with a nodata value of zero.
  task automatic test_reset_defaults();
    send_pixel(16'h0000, 12'd0, 16'sd0);
    send_pixel(16'h0000, 12'd1, 16'sd9);
    send_pixel(16'h0000, 12'd2, -16'sd9);
    send_pixel(16'h0001, 12'd0, -16'sd7);
    send_pixel(16'h0001, 12'd1, 16'sd0);
  endtask

  task automatic test_field_extremes();
    reconfigure(MODE_MEAN, 16'sh8000);
    send_pixel(16'hFFFF, 12'd0, 16'sh7FFF);
    send_pixel(16'hFFFF, 12'hFFF, 16'sh8001);
    send_pixel(16'hFFFF, 12'd2, 16'sh8000);
    // A negative mean must truncate towards zero.
    send_pixel(16'h8000, 12'd0, -16'sd5);
    send_pixel(16'h8000, 12'd1, 16'sd2);
    reconfigure(MODE_MIN, 16'sh7FFF);
    send_pixel(16'h0001, 12'd0, 16'sh7FFF);
    send_pixel(16'h0001, 12'd1, 16'sd100);
    send_pixel(16'h0001, 12'd2, 16'sd200);
    send_pixel(16'h0001, 12'd3, 16'sh8000);
    reconfigure(MODE_MAX, 16'sh0000);
    send_pixel(16'h0002, 12'd0, 16'sd0);
    send_pixel(16'h0002, 12'd1, -16'sd5);
    send_pixel(16'h0002, 12'd2, -16'sd7);
    send_pixel(16'h0002, 12'd3, 16'sh7FFF);
    reconfigure(MODE_SUM, 16'shFFFF);
    send_pixel(16'h0003, 12'd0, 16'sh7FFF);
    send_pixel(16'h0003, 12'd1, 16'shFFFF);
    send_pixel(16'h0003, 12'd2, 16'sh8000);
    send_pixel(16'h0003, 12'h800, 16'sh7FFF);
  endtask

  // Sums build values far outside the sample range, which the other modes then fold on.
  task automatic test_mode_switch();
    int k;
    int ras;
    reconfigure(MODE_SUM, 16'sh8000);
    for (ras = 0; ras < 10; ras++)
      for (k = 0; k < 6; k++)
        send_pixel(PIX_W'(16'h00F0 + k), RAS_W'(ras), (k % 2) ? 16'sh8001 : 16'sh7FFF);
    reconfigure(MODE_MEAN, 16'sh0000);
    for (ras = 10; ras < 15; ras++)
      for (k = 0; k < 6; k++) send_pixel(PIX_W'(16'h00F0 + k), RAS_W'(ras), pick_sample());
    reconfigure(MODE_MIN, 16'sh7FFF);
    for (ras = 15; ras < 17; ras++)
      for (k = 0; k < 6; k++) send_pixel(PIX_W'(16'h00F0 + k), RAS_W'(ras), pick_sample());
    reconfigure(MODE_MAX, 16'sh8000);
    for (ras = 17; ras < 19; ras++)
      for (k = 0; k < 6; k++) send_pixel(PIX_W'(16'h00F0 + k), RAS_W'(ras), pick_sample());
  endtask

  task automatic test_random_phases();
    logic signed [SMP_W-1:0] nodata;
    int                      n;
    for (n = 0; n < 12; n++) begin
      case (n % 4)
        0:       nodata = 16'sh0000;
        1:       nodata = 16'sh8000;
        2:       nodata = 16'sh7FFF;
        default: nodata = SMP_W'($urandom_range(0, 65535));
      endcase
      tx_gaps   = (n % 3 != 2);
      rx_random = (n % 3 != 1);
      reconfigure(agg_mode_t'((n + n / 4) % 4), nodata);
      random_stacks(105);
    end
  endtask

  // The receiver holds off while distinct pixels stream in, so the pipeline backs up.
  task automatic test_output_hold_off();
    int k;
    reconfigure(MODE_MEAN, SMP_W'($urandom_range(0, 65535)));
    tx_gaps      = 1'b0;
    rx_random    = 1'b1;
    hold_off_len = 300;
    -> hold_off_ev;
    for (k = 0; k < 120; k++)
      send_pixel(PIX_W'(16'h4000 + k % 40), RAS_W'(k / 40), pick_sample());
  endtask

  task automatic test_sender_pause();
    reconfigure(MODE_SUM, SMP_W'($urandom_range(0, 65535)));
    tx_gaps = 1'b1;
    random_stacks(30);
    wait_results_drained();
    random_stacks(30);
  endtask

  always begin
    @(hold_off_ev);
    hold_active <= 1'b1;
    repeat (hold_off_len) @(posedge clk);
    hold_active <= 1'b0;
  end

  always @(posedge clk) begin
    if (rx_run_left == 0) begin
      rx_stalling = ($urandom_range(0, 3) == 0);
      rx_run_left = rx_stalling ? $urandom_range(1, 5) : $urandom_range(1, 16);
    end
    rx_run_left--;
    agg_ready <= !hold_active && !(rx_random && rx_stalling);
  end

  always @(posedge clk) begin : check_result
    agg_item_t want;
    if (!rst && agg_valid && agg_ready) begin
      if (pending_aggs.size() == 0) begin
        if (count_mismatch())
          $display("Result for pixel %0d (value %0d) with no item outstanding",
                   agg_data.out_pixel_index, agg_data.aggregate_value);
      end else begin
        want = pending_aggs.pop_front();
        if (agg_data.out_pixel_index !== want.out_pixel_index) begin
          if (count_mismatch())
            $display("Pixel index mismatch: expected %0d, got %0d",
                     want.out_pixel_index, agg_data.out_pixel_index);
        end
        if (agg_data.aggregate_value !== want.aggregate_value) begin
          if (count_mismatch())
            $display("Aggregate mismatch on pixel %0d: expected %0d, got %0d",
                     want.out_pixel_index, want.aggregate_value, agg_data.aggregate_value);
        end
      end
    end
  end

  initial begin
    cur_mode   = MODE_MEAN;
    cur_nodata = '0;
    rst       <= 1'b1;
    px_valid  <= 1'b0;
    px_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_AGG_MODE;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_field_extremes();
    test_mode_switch();
    test_random_phases();
    test_output_hold_off();
    test_sender_pause();
    wait_results_drained();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
